// File: hw/rtl/bc_pkg.sv
// shared types and constants for the binomial coefficient core
// used by bc_datapath, bc_controller and binomial_coefficient_core; no dependencies
package bc_pkg;

  localparam int MAX_N   = 62;
  localparam int FIELD_W = 6;
  localparam int COEF_W  = 59;
  // columns of pascal's triangle kept, up to min(k, n-k) at the largest n
  localparam int LANES   = MAX_N / 2 + 1;
  localparam int IDX_W   = $clog2(LANES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ZERO,
    KIND_SAT
  } kind_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
  } dp_status_t;

endpackage

// File: hw/rtl/bc_datapath.sv
// datapath: row counter, pascal row lanes and result register
// depends on bc_pkg; driven by bc_controller through dp_cmd_t / dp_status_t
module bc_datapath (
  input  logic                       clk,
  input  bc_pkg::dp_cmd_t            cmd,
  output bc_pkg::dp_status_t         status,
  input  logic [bc_pkg::FIELD_W-1:0] n_in,
  input  logic [bc_pkg::FIELD_W-1:0] k_in,
  output logic [bc_pkg::COEF_W-1:0]  result
);
  import bc_pkg::*;

  logic [FIELD_W-1:0] count;
  logic [IDX_W-1:0]   pick;
  kind_t              kind;
  logic [COEF_W-1:0]  lane [LANES];

  logic [FIELD_W-1:0] diff;
  logic [IDX_W-1:0]   pick_next;
  kind_t              kind_next;

  always_comb begin
    diff = n_in - k_in;
    priority if (k_in > n_in) begin
      kind_next = KIND_ZERO;
    end else if (n_in > FIELD_W'(MAX_N)) begin
      kind_next = KIND_SAT;
    end else begin
      kind_next = KIND_NORMAL;
    end
    // symmetric column, only meaningful when k does not exceed n
    if (k_in <= diff) begin
      pick_next = IDX_W'(k_in);
    end else begin
      pick_next = IDX_W'(diff);
    end
  end

  assign status.count_zero = (count == '0);

  // lane j holds C(row, j); each step advances one row of the triangle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= (kind_next == KIND_NORMAL) ? n_in : '0;
      pick  <= pick_next;
      kind  <= kind_next;
      lane[0] <= COEF_W'(1);
      for (int j = 1; j < LANES; j++) begin
        lane[j] <= '0;
      end
    end else if (cmd.step) begin
      count <= count - 1'b1;
      for (int j = 1; j < LANES; j++) begin
        lane[j] <= lane[j] + lane[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (kind)
        KIND_NORMAL: result <= lane[pick];
        KIND_ZERO:   result <= '0;
        KIND_SAT:    result <= '1;
        default:     result <= '1;
      endcase
    end
  end

endmodule

// File: hw/rtl/bc_controller.sv
// controller: sequences load, row steps, result capture and the done strobe
// depends on bc_pkg; commands bc_datapath through dp_cmd_t / dp_status_t
module bc_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output bc_pkg::dp_cmd_t    cmd,
  input  bc_pkg::dp_status_t status
);
  import bc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    done       = (state == ST_EMIT);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.count_zero) begin
          cmd.finish = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EMIT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |=> state == ST_IDLE)
    else $error("done strobe lasted more than one cycle");

  a_finish_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done)
    else $error("captured result not presented");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.finish))
    else $error("done without a captured result");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy)
    else $error("load while busy");

  a_step_needs_rows: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.count_zero && !cmd.finish)
    else $error("row step past the last row");
`endif

endmodule

// File: hw/rtl/binomial_coefficient_core.sv
// binomial coefficient core: exact C(n, k) for n up to MAX_N, 59-bit result
// depends on bc_pkg, bc_controller and bc_datapath
//
// usage:
//   input beat: drive n_total and k_chosen with start high; the beat is taken
//   at the rising edge where start is high and busy is low. busy stays high
//   until the result has been shown.
//   result beat: done is high for exactly one cycle with coefficient valid;
//   the receiver must take it then, there is no back-pressure.
// row loop:
//   the row loop builds pascal's triangle one row per cycle over 32 lanes,
//   31 of them with 59-bit adders; the load, n row steps, the result capture
//   and the done beat follow in that order, and the next item is accepted
//   only once busy is low again. k above n or n above MAX_N skip the row
//   steps. k above n gives 0; n above MAX_N gives all ones.
// reset:
//   rst (synchronous, active high) returns the controller to idle, drops busy
//   and done; an item in flight is dropped.
module binomial_coefficient_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [bc_pkg::FIELD_W-1:0] n_total,
  input  logic [bc_pkg::FIELD_W-1:0] k_chosen,
  output logic                       done,
  output logic [bc_pkg::COEF_W-1:0]  coefficient
);
  import bc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bc_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  bc_datapath u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .status (status),
    .n_in   (n_total),
    .k_in   (k_chosen),
    .result (coefficient)
  );

endmodule
